FILE: design/dd_pkg.sv
// package: shared constants, state type and calendar tables for date difference
`timescale 1ns / 1ps
package dd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  localparam int unsigned DoyW   = 9;

  localparam logic [YearW-1:0]  YearMin  = 14'd1;
  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [MonthW-1:0] MonthMin = 4'd1;
  localparam logic [MonthW-1:0] MonthMax = 4'd12;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [DayW-1:0]   DayMin   = 5'd1;
  localparam logic [DayW-1:0]   FebLeap  = 5'd29;
  localparam logic [6:0]        Mod100Top = 7'd99;
  localparam logic [8:0]        Mod400Top = 9'd399;
  localparam logic [CountW-1:0] YearDays  = 22'd365;

  // one-hot sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WALK = 5'b00010,
    ST_DOY  = 5'b00100,
    ST_DIFF = 5'b01000,
    ST_HOLD = 5'b10000
  } state_e;

  // length of a month in a common year
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      default: n = 9'd334;
    endcase
    return n;
  endfunction

endpackage

FILE: design/date_difference_days.sv
// top level: absolute day count between two gregorian dates by a year walk
//
//  channel  direction  handshake                 word
//  in       input      in_valid_i / in_stall_o   two dates (day, month, year each)
//  out      output     out_valid_o / out_stall_i day_count_o
//
// a word's run time is set by the year walk from year 1 to the larger year,
// one year per cycle through one adder.
// rst_ni clears the sequencer and the output valid; data registers are not reset.
// a finished count waits in the output register, so the next word is taken then;
// a new count leaves the sequencer only once that register is free.
`timescale 1ns / 1ps
module date_difference_days (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dd_pkg::DayW-1:0]        first_day_i,
  input  logic [dd_pkg::MonthW-1:0]      first_month_i,
  input  logic [dd_pkg::YearW-1:0]       first_year_i,
  input  logic [dd_pkg::DayW-1:0]        second_day_i,
  input  logic [dd_pkg::MonthW-1:0]      second_month_i,
  input  logic [dd_pkg::YearW-1:0]       second_year_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dd_pkg::CountW-1:0]      day_count_o
);

  dd_pkg::state_e state_q, state_d;

  logic [dd_pkg::YearW-1:0]  ylo_q, yhi_q, y_q;
  logic [dd_pkg::MonthW-1:0] mlo_q, mhi_q;
  logic [dd_pkg::DayW-1:0]   dlo_q, dhi_q;
  logic [6:0]                m100_q;
  logic [8:0]                m400_q;
  logic [dd_pkg::CountW-1:0] acc_q;
  logic                      leap_lo_q, leap_hi_q;
  logic [dd_pkg::DoyW-1:0]   doy_lo_q, doy_hi_q;
  logic                      out_valid_q;
  logic [dd_pkg::CountW-1:0] out_q;

  // clamped input fields
  logic [dd_pkg::YearW-1:0]  y1, y2;
  logic [dd_pkg::MonthW-1:0] m1, m2;
  logic [dd_pkg::DayW-1:0]   d1, d2;
  logic                      swap;

  always_comb begin
    y1 = first_year_i;
    if (y1 < dd_pkg::YearMin) y1 = dd_pkg::YearMin;
    if (y1 > dd_pkg::YearMax) y1 = dd_pkg::YearMax;
    y2 = second_year_i;
    if (y2 < dd_pkg::YearMin) y2 = dd_pkg::YearMin;
    if (y2 > dd_pkg::YearMax) y2 = dd_pkg::YearMax;
    m1 = first_month_i;
    if (m1 < dd_pkg::MonthMin) m1 = dd_pkg::MonthMin;
    if (m1 > dd_pkg::MonthMax) m1 = dd_pkg::MonthMax;
    m2 = second_month_i;
    if (m2 < dd_pkg::MonthMin) m2 = dd_pkg::MonthMin;
    if (m2 > dd_pkg::MonthMax) m2 = dd_pkg::MonthMax;
    d1 = (first_day_i < dd_pkg::DayMin) ? dd_pkg::DayMin : first_day_i;
    d2 = (second_day_i < dd_pkg::DayMin) ? dd_pkg::DayMin : second_day_i;
    swap = (y1 > y2);
  end

  // leap test of the walk year from its running residues
  logic walk_leap, walk_in_span, walk_last;
  assign walk_leap    = ((y_q[1:0] == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign walk_in_span = (y_q >= ylo_q) && (y_q < yhi_q);
  assign walk_last    = (y_q == yhi_q);

  // day of year with the day clamped to its month
  logic [dd_pkg::DayW-1:0] len_lo, len_hi, dc_lo, dc_hi;
  logic [dd_pkg::DoyW-1:0] doy_lo, doy_hi;

  always_comb begin
    len_lo = (mlo_q == dd_pkg::MonthFeb && leap_lo_q) ? dd_pkg::FebLeap
                                                      : dd_pkg::month_len(mlo_q);
    len_hi = (mhi_q == dd_pkg::MonthFeb && leap_hi_q) ? dd_pkg::FebLeap
                                                      : dd_pkg::month_len(mhi_q);
    dc_lo  = (dlo_q > len_lo) ? len_lo : dlo_q;
    dc_hi  = (dhi_q > len_hi) ? len_hi : dhi_q;
    doy_lo = dd_pkg::days_before(mlo_q) + dd_pkg::DoyW'(dc_lo)
           + dd_pkg::DoyW'((mlo_q > dd_pkg::MonthFeb) && leap_lo_q);
    doy_hi = dd_pkg::days_before(mhi_q) + dd_pkg::DoyW'(dc_hi)
           + dd_pkg::DoyW'((mhi_q > dd_pkg::MonthFeb) && leap_hi_q);
  end

  // final combine: year span plus later offset minus earlier offset, absolute
  logic [dd_pkg::CountW-1:0] sum_hi, diff;
  always_comb begin
    sum_hi = acc_q + dd_pkg::CountW'(doy_hi_q);
    diff   = (sum_hi >= dd_pkg::CountW'(doy_lo_q)) ? sum_hi - dd_pkg::CountW'(doy_lo_q)
                                                   : dd_pkg::CountW'(doy_lo_q) - sum_hi;
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      dd_pkg::ST_IDLE: if (in_valid_i) state_d = dd_pkg::ST_WALK;
      dd_pkg::ST_WALK: if (walk_last) state_d = dd_pkg::ST_DOY;
      dd_pkg::ST_DOY:  state_d = dd_pkg::ST_DIFF;
      dd_pkg::ST_DIFF: state_d = dd_pkg::ST_HOLD;
      dd_pkg::ST_HOLD: if (out_free) state_d = dd_pkg::ST_IDLE;
      default:         state_d = dd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture, walk and combine datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      dd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ylo_q  <= swap ? y2 : y1;
          mlo_q  <= swap ? m2 : m1;
          dlo_q  <= swap ? d2 : d1;
          yhi_q  <= swap ? y1 : y2;
          mhi_q  <= swap ? m1 : m2;
          dhi_q  <= swap ? d1 : d2;
          y_q    <= dd_pkg::YearMin;
          m100_q <= 7'd1;
          m400_q <= 9'd1;
          acc_q  <= '0;
        end
      end
      dd_pkg::ST_WALK: begin
        if (y_q == ylo_q) leap_lo_q <= walk_leap;
        if (walk_last) leap_hi_q <= walk_leap;
        if (walk_in_span) acc_q <= acc_q + dd_pkg::YearDays + dd_pkg::CountW'(walk_leap);
        y_q    <= y_q + 1'b1;
        m100_q <= (m100_q == dd_pkg::Mod100Top) ? 7'd0 : m100_q + 1'b1;
        m400_q <= (m400_q == dd_pkg::Mod400Top) ? 9'd0 : m400_q + 1'b1;
      end
      dd_pkg::ST_DOY: begin
        doy_lo_q <= doy_lo;
        doy_hi_q <= doy_hi;
      end
      dd_pkg::ST_DIFF: begin
        acc_q <= diff;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == dd_pkg::ST_HOLD && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dd_pkg::ST_HOLD && out_free) begin
      out_q <= acc_q;
    end
  end

  assign in_stall_o  = (state_q != dd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign day_count_o = out_q;

endmodule
